// ===== hw/rtl/sscg_pkg.sv =====
// ----------------------------------------------------------------------------
// sscg_pkg - shared types and constants for the settings commit guard
// Slot layout, field widths, command/status/link codes and the register file
// layout used by the top level and the commit checker.
// ----------------------------------------------------------------------------
package sscg_pkg;

  // Slot layout
  localparam int SLOT_COUNT  = 8;
  localparam int ADDR_SLOT   = 0;
  localparam int SPEED_SLOT  = 1;
  localparam int PARITY_SLOT = 2;
  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Array index of each checked slot; folded into range, only meaningful
  // when the slot exists (its dirty bit is zero otherwise)
  localparam logic [SLOT_W-1:0] ADDR_IDX   = SLOT_W'(ADDR_SLOT % SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SPEED_IDX  = SLOT_W'(SPEED_SLOT % SLOT_COUNT);
  localparam logic [SLOT_W-1:0] PARITY_IDX = SLOT_W'(PARITY_SLOT % SLOT_COUNT);

  // Field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 16;
  localparam int TIME_W     = 32;
  localparam int LINK_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_IDLE        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STAGED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COMMIT_OK   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJ_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJ_LINK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REJ_RUNNING = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 3'd6;

  // Arrival links
  localparam logic [LINK_W-1:0] LINK_SERIAL = 2'd1;
  localparam logic [LINK_W-1:0] LINK_ETHER  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_MASK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ETHER_MASK  = 3'd6;

  typedef struct packed {
    logic [VAL_W-1:0]  addr_min;
    logic [VAL_W-1:0]  addr_max;
    logic [VAL_W-1:0]  speed_max;
    logic [VAL_W-1:0]  parity_max;
    logic [TIME_W-1:0] timeout_ms;
    logic [VAL_W-1:0]  serial_mask;
    logic [VAL_W-1:0]  ether_mask;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    addr_min:    16'd1,
    addr_max:    16'd247,
    speed_max:   16'd7,
    parity_max:  16'd2,
    timeout_ms:  32'd30000,
    serial_mask: 16'd7,
    ether_mask:  16'd248
  };

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                applied;
  } check_res_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                applied;
    logic                dirty;
    logic [VAL_W-1:0]    value;
  } result_t;

endpackage

// ===== hw/rtl/sscg_commit_check.sv =====
// ----------------------------------------------------------------------------
// sscg_commit_check - commit validation
// Range, same-link and running checks in priority order over the pending
// dirty set; gives the commit status and whether the commit applies.
// ----------------------------------------------------------------------------
module sscg_commit_check (
  input  sscg_pkg::cfg_regs_t                cfg_i,
  input  logic [sscg_pkg::SLOT_COUNT-1:0]    dirty_i,
  input  logic [sscg_pkg::VAL_W-1:0]         addr_val_i,
  input  logic [sscg_pkg::VAL_W-1:0]         speed_val_i,
  input  logic [sscg_pkg::VAL_W-1:0]         parity_val_i,
  input  logic [sscg_pkg::LINK_W-1:0]        link_i,
  input  logic                               running_i,
  output sscg_pkg::check_res_t               res_o
);

  logic [sscg_pkg::MAX_SLOTS-1:0] dirty_ext;
  logic                           addr_bad;
  logic                           speed_bad;
  logic                           parity_bad;
  logic                           link_bad;

  assign dirty_ext = sscg_pkg::MAX_SLOTS'(dirty_i);

  assign addr_bad   = dirty_ext[sscg_pkg::ADDR_SLOT] &&
                      ((addr_val_i < cfg_i.addr_min) || (addr_val_i > cfg_i.addr_max));
  assign speed_bad  = dirty_ext[sscg_pkg::SPEED_SLOT] && (speed_val_i > cfg_i.speed_max);
  assign parity_bad = dirty_ext[sscg_pkg::PARITY_SLOT] && (parity_val_i > cfg_i.parity_max);

  // mask bits above the slot count are ignored
  assign link_bad =
    ((link_i == sscg_pkg::LINK_SERIAL) &&
     (|(dirty_i & cfg_i.serial_mask[sscg_pkg::SLOT_COUNT-1:0]))) ||
    ((link_i == sscg_pkg::LINK_ETHER) &&
     (|(dirty_i & cfg_i.ether_mask[sscg_pkg::SLOT_COUNT-1:0])));

  always_comb begin
    res_o.applied = 1'b0;
    priority if (!(|dirty_i)) begin
      res_o.status = sscg_pkg::ST_COMMIT_OK;     // empty commit
    end else if (addr_bad || speed_bad || parity_bad) begin
      res_o.status = sscg_pkg::ST_REJ_RANGE;
    end else if (link_bad) begin
      res_o.status = sscg_pkg::ST_REJ_LINK;
    end else if (running_i) begin
      res_o.status = sscg_pkg::ST_REJ_RUNNING;
    end else begin
      res_o.status  = sscg_pkg::ST_COMMIT_OK;
      res_o.applied = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/staged_settings_commit_guard.sv =====
// ----------------------------------------------------------------------------
// staged_settings_commit_guard - shadow settings staging with guarded commit
// Holds staged slot values and dirty bits, expires them on timeout and
// validates commits against range, arrival link and machine state.
// ----------------------------------------------------------------------------
// Every input beat is one command (write, discard, tick, commit) and gives
// exactly one result beat. The command is decoded and the staging state
// updated in a single pass of short logic, with the result captured in the
// output register on the accepting edge (or in the skid buffer while the
// output is held); one beat can be taken every cycle while in_stall is low.
// A one-entry skid buffer behind the output register lets the block take
// the next beat while a result is held by out_stall; in_stall rises only
// when both are full. Staged values survive discard, timeout and commit;
// only the dirty bits clear. Registers are written through the cfg_ port at
// any time (cfg_ready is always high) and should only change while idle.
// ----------------------------------------------------------------------------
module staged_settings_commit_guard (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sscg_pkg::CMD_W-1:0]         in_cmd,
  input  logic [sscg_pkg::IDX_W-1:0]         in_slot_index,
  input  logic [sscg_pkg::VAL_W-1:0]         in_write_value,
  input  logic [sscg_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [sscg_pkg::LINK_W-1:0]        in_arrival_link,
  input  logic                               in_machine_running,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sscg_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_commit_applied,
  output logic                               out_slot_dirty,
  output logic [sscg_pkg::VAL_W-1:0]         out_slot_value,
  // register write port
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sscg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sscg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Register file
  sscg_pkg::cfg_regs_t cfg_r;

  // Staging state
  logic [sscg_pkg::VAL_W-1:0]      staged_r [sscg_pkg::SLOT_COUNT];
  logic [sscg_pkg::SLOT_COUNT-1:0] dirty_r;
  logic [sscg_pkg::SLOT_COUNT-1:0] dirty_nxt;
  logic [sscg_pkg::TIME_W-1:0]     last_r;
  logic [sscg_pkg::TIME_W-1:0]     last_nxt;
  logic [sscg_pkg::STATUS_W-1:0]   status_r;
  logic [sscg_pkg::STATUS_W-1:0]   status_nxt;

  // Output register and skid
  sscg_pkg::result_t out_r;
  sscg_pkg::result_t skid_r;
  sscg_pkg::result_t res_nxt;
  logic              out_valid_r;
  logic              skid_valid_r;

  logic                          accept;
  logic                          drain;
  logic                          slot_ok;
  logic                          wr_en;
  logic                          applied_nxt;
  logic [sscg_pkg::SLOT_W-1:0]   slot_sel;
  logic [sscg_pkg::TIME_W-1:0]   elapsed;
  sscg_pkg::check_res_t          chk;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign drain     = out_valid_r && !out_stall;

  // Indexes past the last slot are ignored on write and read back as zero
  assign slot_ok  = int'(in_slot_index) < sscg_pkg::SLOT_COUNT;
  assign slot_sel = sscg_pkg::SLOT_W'(in_slot_index);
  assign elapsed  = in_now_ms - last_r;   // wraps mod 2^32

  sscg_commit_check u_check (
    .cfg_i        (cfg_r),
    .dirty_i      (dirty_r),
    .addr_val_i   (staged_r[sscg_pkg::ADDR_IDX]),
    .speed_val_i  (staged_r[sscg_pkg::SPEED_IDX]),
    .parity_val_i (staged_r[sscg_pkg::PARITY_IDX]),
    .link_i       (in_arrival_link),
    .running_i    (in_machine_running),
    .res_o        (chk)
  );

  // Command decode: next staging state
  always_comb begin
    dirty_nxt   = dirty_r;
    last_nxt    = last_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    applied_nxt = 1'b0;
    unique case (in_cmd)
      sscg_pkg::CMD_WRITE: begin
        if (slot_ok) begin
          wr_en      = 1'b1;
          dirty_nxt  = dirty_r | (sscg_pkg::SLOT_COUNT'(1) << slot_sel);
          last_nxt   = in_now_ms;
          status_nxt = sscg_pkg::ST_STAGED;
        end
      end
      sscg_pkg::CMD_DISCARD: begin
        dirty_nxt  = '0;
        status_nxt = sscg_pkg::ST_IDLE;
      end
      sscg_pkg::CMD_TICK: begin
        // expiry only while something is pending
        if ((|dirty_r) && (elapsed >= cfg_r.timeout_ms)) begin
          dirty_nxt  = '0;
          status_nxt = sscg_pkg::ST_TIMEOUT;
        end
      end
      sscg_pkg::CMD_COMMIT: begin
        status_nxt  = chk.status;
        applied_nxt = chk.applied;
        if (chk.applied) begin
          dirty_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result beat reflects state after this command
  always_comb begin
    res_nxt.status  = status_nxt;
    res_nxt.applied = applied_nxt;
    res_nxt.dirty   = slot_ok && dirty_nxt[slot_sel];
    if (!slot_ok) begin
      res_nxt.value = '0;
    end else if (wr_en) begin
      res_nxt.value = in_write_value;
    end else begin
      res_nxt.value = staged_r[slot_sel];
    end
  end

  // Register file writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= sscg_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sscg_pkg::REG_ADDR_MIN:    cfg_r.addr_min    <= cfg_data[sscg_pkg::VAL_W-1:0];
        sscg_pkg::REG_ADDR_MAX:    cfg_r.addr_max    <= cfg_data[sscg_pkg::VAL_W-1:0];
        sscg_pkg::REG_SPEED_MAX:   cfg_r.speed_max   <= cfg_data[sscg_pkg::VAL_W-1:0];
        sscg_pkg::REG_PARITY_MAX:  cfg_r.parity_max  <= cfg_data[sscg_pkg::VAL_W-1:0];
        sscg_pkg::REG_TIMEOUT_MS:  cfg_r.timeout_ms  <= cfg_data[sscg_pkg::TIME_W-1:0];
        sscg_pkg::REG_SERIAL_MASK: cfg_r.serial_mask <= cfg_data[sscg_pkg::VAL_W-1:0];
        sscg_pkg::REG_ETHER_MASK:  cfg_r.ether_mask  <= cfg_data[sscg_pkg::VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Staging state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sscg_pkg::SLOT_COUNT; i++) begin
        staged_r[i] <= '0;
      end
      dirty_r  <= '0;
      last_r   <= '0;
      status_r <= sscg_pkg::ST_IDLE;
    end else if (accept) begin
      if (wr_en) begin
        staged_r[slot_sel] <= in_write_value;
      end
      dirty_r  <= dirty_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
    end
  end

  // Output register with skid: skid fills only when the output is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || drain) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (accept) begin
      skid_r       <= res_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_commit_applied = out_r.applied;
  assign out_slot_dirty     = out_r.dirty;
  assign out_slot_value     = out_r.value;

  // Skid only ever holds a beat behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat with output register empty");

  // An applied commit leaves nothing pending
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == sscg_pkg::CMD_COMMIT) && chk.applied) |=> (dirty_r == '0))
    else $error("dirty bits survive an applied commit");

  // Applied is only reported with a commit-ok status
  a_applied_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.applied) |-> (out_r.status == sscg_pkg::ST_COMMIT_OK))
    else $error("commit applied reported with a reject status");

  // An in-range write leaves the block staged with that slot dirty
  a_write_stages: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == sscg_pkg::CMD_WRITE) && slot_ok) |=>
      ((status_r == sscg_pkg::ST_STAGED) && (dirty_r != '0)))
    else $error("write did not stage");

endmodule

// ===== test/staged_settings_commit_guard_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_settings_commit_guard_checker - result scoreboard for the commit guard
// Follows register writes and command beats, keeps its own copy of the
// staging state, predicts one result per command and compares every result
// beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module staged_settings_commit_guard_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [sscg_pkg::CMD_W-1:0]         in_cmd,
  input  logic [sscg_pkg::IDX_W-1:0]         in_slot_index,
  input  logic [sscg_pkg::VAL_W-1:0]         in_write_value,
  input  logic [sscg_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [sscg_pkg::LINK_W-1:0]        in_arrival_link,
  input  logic                               in_machine_running,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [sscg_pkg::STATUS_W-1:0]      out_status,
  input  logic                               out_commit_applied,
  input  logic                               out_slot_dirty,
  input  logic [sscg_pkg::VAL_W-1:0]         out_slot_value,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [sscg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sscg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 mismatch_count,
  output int                                 results_owed
);
  import sscg_pkg::*;

  // shadow of the block's staging state and registers
  cfg_regs_t             shadow_cfg;
  logic [VAL_W-1:0]      shadow_vals [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] shadow_dirty;
  logic [TIME_W-1:0]     shadow_stamp;
  logic [STATUS_W-1:0]   shadow_status;

  result_t owed_results [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  task automatic log_mismatch(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ADDR_MIN:    shadow_cfg.addr_min    = data[VAL_W-1:0];
      REG_ADDR_MAX:    shadow_cfg.addr_max    = data[VAL_W-1:0];
      REG_SPEED_MAX:   shadow_cfg.speed_max   = data[VAL_W-1:0];
      REG_PARITY_MAX:  shadow_cfg.parity_max  = data[VAL_W-1:0];
      REG_TIMEOUT_MS:  shadow_cfg.timeout_ms  = data[TIME_W-1:0];
      REG_SERIAL_MASK: shadow_cfg.serial_mask = data[VAL_W-1:0];
      REG_ETHER_MASK:  shadow_cfg.ether_mask  = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  // Applies one command to the shadow state and returns the result it gives
  function automatic result_t stage_command(input logic [CMD_W-1:0]  cmd,
                                            input logic [IDX_W-1:0]  idx,
                                            input logic [VAL_W-1:0]  val,
                                            input logic [TIME_W-1:0] now,
                                            input logic [LINK_W-1:0] link,
                                            input logic              running);
    result_t           res;
    logic [TIME_W-1:0] elapsed;
    logic              range_bad;
    logic              link_bad;
    logic [VAL_W-1:0]  addr_v;
    res.applied = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        shadow_vals[idx]  = val;
        shadow_dirty[idx] = 1'b1;
        shadow_stamp      = now;
        shadow_status     = ST_STAGED;
      end
      CMD_DISCARD: begin
        shadow_dirty  = '0;
        shadow_status = ST_IDLE;
      end
      CMD_TICK: begin
        elapsed = now - shadow_stamp;
        if (shadow_dirty != '0 && elapsed >= shadow_cfg.timeout_ms) begin
          shadow_dirty  = '0;
          shadow_status = ST_TIMEOUT;
        end
      end
      default: begin
        addr_v    = shadow_vals[ADDR_SLOT];
        range_bad = (shadow_dirty[ADDR_SLOT] &&
                     (addr_v < shadow_cfg.addr_min || addr_v > shadow_cfg.addr_max)) ||
                    (shadow_dirty[SPEED_SLOT] &&
                     shadow_vals[SPEED_SLOT] > shadow_cfg.speed_max) ||
                    (shadow_dirty[PARITY_SLOT] &&
                     shadow_vals[PARITY_SLOT] > shadow_cfg.parity_max);
        link_bad  = (link == LINK_SERIAL &&
                     |(shadow_dirty & shadow_cfg.serial_mask[SLOT_COUNT-1:0])) ||
                    (link == LINK_ETHER &&
                     |(shadow_dirty & shadow_cfg.ether_mask[SLOT_COUNT-1:0]));
        if (shadow_dirty == '0)
          shadow_status = ST_COMMIT_OK;
        else if (range_bad)
          shadow_status = ST_REJ_RANGE;
        else if (link_bad)
          shadow_status = ST_REJ_LINK;
        else if (running)
          shadow_status = ST_REJ_RUNNING;
        else begin
          shadow_dirty  = '0;
          shadow_status = ST_COMMIT_OK;
          res.applied   = 1'b1;
        end
      end
    endcase
    res.status = shadow_status;
    res.dirty  = shadow_dirty[idx];
    res.value  = shadow_vals[idx];
    return res;
  endfunction

  task automatic check_result();
    result_t want;
    if (owed_results.size() == 0) begin
      log_mismatch("result beat with nothing owed, status", '0, 32'(out_status));
    end else begin
      want = owed_results.pop_front();
      if (out_status !== want.status)
        log_mismatch("status", 32'(want.status), 32'(out_status));
      if (out_commit_applied !== want.applied)
        log_mismatch("commit_applied", 32'(want.applied), 32'(out_commit_applied));
      if (out_slot_dirty !== want.dirty)
        log_mismatch("slot_dirty", 32'(want.dirty), 32'(out_slot_dirty));
      if (out_slot_value !== want.value)
        log_mismatch("slot_value", 32'(want.value), 32'(out_slot_value));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg    = CFG_RESET;
      foreach (shadow_vals[i]) shadow_vals[i] = '0;
      shadow_dirty  = '0;
      shadow_stamp  = '0;
      shadow_status = ST_IDLE;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        load_register(cfg_index, cfg_data);
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        owed_results.push_back(stage_command(in_cmd, in_slot_index, in_write_value,
                                             in_now_ms, in_arrival_link,
                                             in_machine_running));
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== test/staged_settings_commit_guard_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_settings_commit_guard_tb - testbench top for the commit guard
// Drives command beats and register writes, stalls the result channel at
// random and leaves all checking to the scoreboard beside the block. A short
// directed run walks the commit checks, retained values and the timer wrap;
// random phases under several register settings follow.
// ----------------------------------------------------------------------------
module staged_settings_commit_guard_tb;
  import sscg_pkg::*;

  // no beat on any channel for this long means the block has hung
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int LONG_HOLD       = 150;
  localparam int TAIL_CYCLES     = 10;

  // index past the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [LINK_W-1:0] LINK_OTHER   = 2'd0;
  localparam logic [LINK_W-1:0] LINK_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd;
  logic [IDX_W-1:0]      in_slot_index;
  logic [VAL_W-1:0]      in_write_value;
  logic [TIME_W-1:0]     in_now_ms;
  logic [LINK_W-1:0]     in_arrival_link;
  logic                  in_machine_running;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_commit_applied;
  logic                  out_slot_dirty;
  logic [VAL_W-1:0]      out_slot_value;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int results_owed;

  // stimulus-side view of the settings and the clock, used only to aim
  // values and ticks at the interesting boundaries
  cfg_regs_t         settings;
  logic [TIME_W-1:0] ms_now;
  logic [TIME_W-1:0] edit_stamp_ms;
  int                items_sent;
  bit                tx_quiet;   // sender offers back to back
  bit                rx_quiet;   // receiver never stalls
  int                rx_hold;    // pending long hold-off, in cycles

  staged_settings_commit_guard i_dut (.*);

  staged_settings_commit_guard_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All driving happens at the falling edge; every task
  // starts and ends there.
  // --------------------------------------------------------------------------

  // One command beat, preceded by a random gap unless the sender is quiet.
  // in_valid is only lowered when a gap is taken, so back-to-back beats
  // keep it high without a second assignment in the same step.
  task automatic offer_cmd(input logic [CMD_W-1:0]  cmd,
                           input logic [IDX_W-1:0]  idx,
                           input logic [VAL_W-1:0]  val,
                           input logic [TIME_W-1:0] now,
                           input logic [LINK_W-1:0] link,
                           input logic              running);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_slot_index      <= idx;
    in_write_value     <= val;
    in_now_ms          <= now;
    in_arrival_link    <= link;
    in_machine_running <= running;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_WRITE)
      edit_stamp_ms = now;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // 16-bit registers get junk in the upper half, which must be dropped
  task automatic load_settings();
    write_register(REG_ADDR_MIN,    {16'($urandom), settings.addr_min});
    write_register(REG_ADDR_MAX,    {16'($urandom), settings.addr_max});
    write_register(REG_SPEED_MAX,   {16'($urandom), settings.speed_max});
    write_register(REG_PARITY_MAX,  {16'($urandom), settings.parity_max});
    write_register(REG_TIMEOUT_MS,  settings.timeout_ms);
    write_register(REG_SERIAL_MASK, {16'($urandom), settings.serial_mask});
    write_register(REG_ETHER_MASK,  {16'($urandom), settings.ether_mask});
  endtask

  // Sender goes quiet until every owed result has come back. Every command
  // gives a result, so nothing is left in flight once the count is zero.
  task automatic settle();
    in_valid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  // values clustered on the commit range limits of the checked slots
  function automatic logic [VAL_W-1:0] pick_value(input logic [IDX_W-1:0] slot);
    int pick;
    pick = $urandom_range(0, 5);
    if (slot == ADDR_SLOT) begin
      case (pick)
        0: return settings.addr_min - 1'b1;
        1: return settings.addr_min;
        2: return settings.addr_max;
        3: return settings.addr_max + 1'b1;
        4: return VAL_W'($urandom_range(settings.addr_min, settings.addr_max));
        default: return VAL_W'($urandom);
      endcase
    end else if (slot == SPEED_SLOT) begin
      case (pick)
        0, 1: return settings.speed_max;
        2:    return settings.speed_max + 1'b1;
        3:    return VAL_W'($urandom_range(0, settings.speed_max));
        default: return VAL_W'($urandom);
      endcase
    end else if (slot == PARITY_SLOT) begin
      case (pick)
        0, 1: return settings.parity_max;
        2:    return settings.parity_max + 1'b1;
        3:    return VAL_W'($urandom_range(0, settings.parity_max));
        default: return VAL_W'($urandom);
      endcase
    end
    return VAL_W'($urandom);
  endfunction

  // tick times either side of the expiry point, or anywhere
  function automatic logic [TIME_W-1:0] tick_time();
    case ($urandom_range(0, 4))
      0: return edit_stamp_ms + settings.timeout_ms - 32'd1;
      1: return edit_stamp_ms + settings.timeout_ms;
      2: return edit_stamp_ms + settings.timeout_ms + 32'd1;
      3: return ms_now + $urandom_range(0, 400);
      default: return $urandom;
    endcase
  endfunction

  // One edit session: a few writes, mostly to the checked slots, then a
  // commit, a tick or a discard, or nothing so edits pile up. Some sessions
  // are just a fully random beat.
  task automatic run_sequence();
    int                shape;
    int                finish;
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] t;
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      offer_cmd(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)),
                VAL_W'($urandom), $urandom,
                LINK_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      slot = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 2))
                                        : IDX_W'($urandom_range(0, 7));
      // time mostly creeps forward, now and then jumps anywhere
      if ($urandom_range(0, 19) == 0)
        ms_now = $urandom;
      else
        ms_now = ms_now + $urandom_range(0, 40);
      offer_cmd(CMD_WRITE, slot, pick_value(slot), ms_now,
                LINK_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    finish = $urandom_range(0, 99);
    if (finish < 55) begin
      offer_cmd(CMD_COMMIT, IDX_W'($urandom_range(0, 7)), VAL_W'($urandom), ms_now,
                LINK_W'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      // retry from a neutral link with the machine stopped
      if ($urandom_range(0, 2) == 0)
        offer_cmd(CMD_COMMIT, IDX_W'($urandom_range(0, 7)), VAL_W'($urandom), ms_now,
                  LINK_OTHER, 1'b0);
    end else if (finish < 72) begin
      t = tick_time();
      offer_cmd(CMD_TICK, IDX_W'($urandom_range(0, 7)), VAL_W'($urandom), t,
                LINK_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      ms_now = t;
    end else if (finish < 82) begin
      offer_cmd(CMD_DISCARD, IDX_W'($urandom_range(0, 7)), VAL_W'($urandom), ms_now,
                LINK_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: after each result beat draw how long to stall the next one.
  // A long hold-off requested by the main flow takes precedence.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int wait_left;
    out_stall = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        wait_left = rx_quiet ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any beat on any channel restarts the count
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main flow
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_cmd             = CMD_WRITE;
    in_slot_index      = '0;
    in_write_value     = '0;
    in_now_ms          = '0;
    in_arrival_link    = LINK_OTHER;
    in_machine_running = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_ADDR_MIN;
    cfg_data           = '0;
    tx_quiet           = 1'b0;
    rx_quiet           = 1'b0;
    rx_hold            = 0;
    items_sent         = 0;
    settings           = CFG_RESET;
    ms_now             = '0;
    edit_stamp_ms      = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset settings: addr 1..247, speed 7, parity 2,
    //      timeout 30000, serial slots 0-2, network slots 3-7
    // commit with nothing dirty: ok, not applied, link and running ignored
    offer_cmd(CMD_COMMIT, 3'd0, 16'hFFFF, 32'd0, LINK_SERIAL, 1'b1);
    // tick with nothing dirty leaves status alone, even at the far end of time
    offer_cmd(CMD_TICK, 3'd7, 16'h0000, 32'hFFFF_FFFF, LINK_OTHER, 1'b0);
    // address below the minimum
    offer_cmd(CMD_WRITE, 3'd0, 16'd0, 32'd100, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd0, 16'd0, 32'd110, LINK_OTHER, 1'b0);
    offer_cmd(CMD_DISCARD, 3'd0, 16'd0, 32'd120, LINK_OTHER, 1'b0);
    // all three checked slots on their upper/lower limits
    offer_cmd(CMD_WRITE, 3'd0, 16'd1, 32'd200, LINK_OTHER, 1'b0);
    offer_cmd(CMD_WRITE, 3'd1, 16'd7, 32'd210, LINK_OTHER, 1'b0);
    offer_cmd(CMD_WRITE, 3'd2, 16'd2, 32'd220, LINK_OTHER, 1'b0);
    // same-link reject over serial, then running reject from an unknown link
    offer_cmd(CMD_COMMIT, 3'd1, 16'd0, 32'd230, LINK_SERIAL, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd2, 16'd0, 32'd231, LINK_UNKNOWN, 1'b1);
    offer_cmd(CMD_COMMIT, 3'd0, 16'd0, 32'd232, LINK_UNKNOWN, 1'b0);
    // staged value survives the commit and the discard
    offer_cmd(CMD_DISCARD, 3'd2, 16'd0, 32'd240, LINK_OTHER, 1'b0);
    // address above the maximum
    offer_cmd(CMD_WRITE, 3'd0, 16'd248, 32'd300, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd0, 16'd0, 32'd301, LINK_OTHER, 1'b0);
    // speed one past its limit
    offer_cmd(CMD_WRITE, 3'd0, 16'd247, 32'd310, LINK_OTHER, 1'b0);
    offer_cmd(CMD_WRITE, 3'd1, 16'd8, 32'd320, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd1, 16'd0, 32'd321, LINK_OTHER, 1'b0);
    // parity one past its limit
    offer_cmd(CMD_WRITE, 3'd1, 16'd0, 32'd330, LINK_OTHER, 1'b0);
    offer_cmd(CMD_WRITE, 3'd2, 16'd3, 32'd340, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd2, 16'd0, 32'd341, LINK_OTHER, 1'b0);
    // top slot, full value, written just before the timer wraps;
    // network arrival hits it through the network mask
    offer_cmd(CMD_WRITE, 3'd2, 16'd0, 32'd350, LINK_OTHER, 1'b0);
    offer_cmd(CMD_WRITE, 3'd7, 16'hFFFF, 32'hFFFF_FF00, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd7, 16'd0, 32'hFFFF_FF01, LINK_ETHER, 1'b0);
    // across the wrap: one short of the timeout, then exactly on it
    offer_cmd(CMD_TICK, 3'd7, 16'd0, 32'd29743, LINK_OTHER, 1'b0);
    offer_cmd(CMD_TICK, 3'd5, 16'd0, 32'd29744, LINK_OTHER, 1'b0);
    offer_cmd(CMD_COMMIT, 3'd7, 16'd0, 32'd29745, LINK_OTHER, 1'b0);
    ms_now = 32'd29745;

    // ---- random phases, each under its own settings
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: settings = '{addr_min: 16'h0000, addr_max: 16'hFFFF, speed_max: 16'hFFFF,
                        parity_max: 16'hFFFF, timeout_ms: 32'd0,
                        serial_mask: 16'hFFFF, ether_mask: 16'hFFFF};
        1: settings = '{addr_min: 16'hFFFF, addr_max: 16'h0000, speed_max: 16'h0000,
                        parity_max: 16'h0000, timeout_ms: 32'hFFFF_FFFF,
                        serial_mask: 16'h0000, ether_mask: 16'h0000};
        2: settings = CFG_RESET;
        default: begin
          settings.addr_min    = VAL_W'($urandom_range(0, 60));
          settings.addr_max    = settings.addr_min + VAL_W'($urandom_range(0, 200));
          settings.speed_max   = VAL_W'($urandom_range(0, 15));
          settings.parity_max  = VAL_W'($urandom_range(0, 4));
          settings.timeout_ms  = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom;
          settings.serial_mask = VAL_W'($urandom);
          settings.ether_mask  = VAL_W'($urandom);
        end
      endcase
      load_settings();
      if (phase == 2)
        write_register(REG_SPARE, $urandom);
      tx_quiet = (phase % 3 == 1);
      rx_quiet = (phase % 4 == 2);
      // receiver holds off while the sender keeps pushing, so the block
      // fills both result registers and has to stall its input
      if (phase == 3) begin
        tx_quiet = 1'b1;
        rx_hold  = LONG_HOLD;
      end
      while (items_sent < 25 + (phase + 1) * ITEMS_PER_PHASE)
        run_sequence();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sscg_pkg.sv
hw/rtl/sscg_commit_check.sv
hw/rtl/staged_settings_commit_guard.sv
test/staged_settings_commit_guard_checker.sv
test/staged_settings_commit_guard_tb.sv
